/* rtl/core/pfalu_pkg.sv */
// ----------------------------------------------------------------------------
// pfalu_pkg
// Shared types and constants of the prime field arithmetic unit: opcodes,
// datapath micro-operations and the status bundle from datapath to control.
// ----------------------------------------------------------------------------
package pfalu_pkg;

  localparam int PFA_WIDTH   = 32;
  localparam int MOD_RESET   = 11;
  localparam int NR_RESET    = 2;
  localparam int IN_TDATA_W  = 72;  // op(3) + a(32) + b(32), byte padded
  localparam int OUT_TDATA_W = 40;  // value(32) + error(1), byte padded

  // Register indexes of the configuration port
  localparam logic REG_MODULUS    = 1'b0;
  localparam logic REG_NONRESIDUE = 1'b1;

  // Opcodes of an input beat
  typedef enum logic [2:0] {
    OPC_ADD  = 3'd0,
    OPC_SUB  = 3'd1,
    OPC_MUL  = 3'd2,
    OPC_NEG  = 3'd3,
    OPC_INV  = 3'd4,
    OPC_POW  = 3'd5,
    OPC_SQRT = 3'd6,
    OPC_LEG  = 3'd7
  } alu_op_t;

  // Micro-operations that the controller hands to the datapath
  typedef enum logic [5:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_ERR,
    OP_MUL_AB,
    OP_POW_AB,
    OP_POW_SQ3,
    OP_POW_AT,
    OP_POW_NT,
    OP_POW_DS,
    OP_POW_LEG,
    OP_POW_MUL,
    OP_POW_SQR,
    OP_EUC_INIT,
    OP_EUC_DIV,
    OP_EUC_MUL,
    OP_EUC_UPD,
    OP_EUC_FIN,
    OP_NR_DIV,
    OP_T_INIT,
    OP_T_STEP,
    OP_S_INIT,
    OP_S_HALF,
    OP_X_ACC,
    OP_C_ACC,
    OP_SQ_D,
    OP_SQ_DINV,
    OP_SQ_XC,
    OP_SQ_CC,
    OP_RES_ACC,
    OP_RES_X,
    OP_RES_INV,
    OP_RES_LEG
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    alu_op_t op;
    logic    bad;
    logic    m_small;
    logic    m_mod3;
    logic    e_zero;
    logic    e_lsb;
    logic    t_lsb;
    logic    s_zero;
    logic    d_one;
    logic    acc_mm1;
    logic    x_zero;
    logic    mul_done;
    logic    div_done;
  } dp_status_t;

endpackage

/* rtl/core/pfalu_dp.sv */
// ----------------------------------------------------------------------------
// pfalu_dp
// Datapath: operand and working registers, a bit-serial modular multiplier
// and a bit-serial divider, driven one micro-operation per cycle.
// ----------------------------------------------------------------------------
module pfalu_dp #(
  parameter int WIDTH = pfalu_pkg::PFA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WIDTH-1:0]     modulus,
  input  logic [WIDTH-1:0]     nonresidue,
  input  logic                 load,
  input  pfalu_pkg::alu_op_t   in_op,
  input  logic [31:0]          in_a,
  input  logic [31:0]          in_b,
  input  pfalu_pkg::dp_op_t    cmd,
  output pfalu_pkg::dp_status_t status,
  output logic [WIDTH-1:0]     res,
  output logic                 err
);
  import pfalu_pkg::*;

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  alu_op_t          op;
  logic             bad;
  logic [WIDTH-1:0] a, b;
  logic [31:0]      e;
  logic [WIDTH-1:0] acc, base;
  logic [WIDTH-1:0] x, y, ca, cb, q, r, tmp, inv;
  logic [WIDTH-1:0] t, s, d, c;

  // multiplier state
  logic             mbusy, mdone;
  logic [WIDTH-1:0] mwalk, madd, mr;
  logic [CW-1:0]    mcnt;
  dp_op_t           mdst;

  // divider state
  logic             dbusy, ddone;
  logic [WIDTH-1:0] dq, drem, dden;
  logic [CW-1:0]    dcnt;

  logic [WIDTH:0]   m_ext;
  logic [WIDTH:0]   sum, dbl, dbl_red, acc_sum, div_try;
  logic [WIDTH-1:0] mr_next, add_res, sub_res, neg_res, nc;
  logic             qbit;

  assign m_ext = {1'b0, modulus};

  // modular add / sub / neg of the operands
  always_comb begin
    sum     = {1'b0, a} + {1'b0, b};
    add_res = (sum >= m_ext) ? WIDTH'(sum - m_ext) : sum[WIDTH-1:0];
    sub_res = (a >= b) ? (a - b) : WIDTH'({1'b0, a} + m_ext - {1'b0, b});
    neg_res = (a != '0) ? (modulus - a) : '0;
    nc      = (cb >= tmp) ? (cb - tmp) : WIDTH'({1'b0, cb} + m_ext - {1'b0, tmp});
  end

  // one multiplier step: r = 2r + bit*addend mod m, MSB first
  always_comb begin
    dbl     = {mr, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    acc_sum = dbl_red + (mwalk[WIDTH-1] ? {1'b0, madd} : '0);
    mr_next = (acc_sum >= m_ext) ? WIDTH'(acc_sum - m_ext) : acc_sum[WIDTH-1:0];
  end

  // one restoring division step
  always_comb begin
    div_try = {drem, dq[WIDTH-1]};
    qbit    = (div_try >= {1'b0, dden});
    if (qbit) begin
      div_try = div_try - {1'b0, dden};
    end
  end

  always_comb begin
    status.op       = op;
    status.bad      = bad;
    status.m_small  = (modulus < WIDTH'(3));
    status.m_mod3   = (modulus[1:0] == 2'b11);
    status.e_zero   = (e == '0);
    status.e_lsb    = e[0];
    status.t_lsb    = t[0];
    status.s_zero   = (s == '0);
    status.d_one    = (d == ONE);
    status.acc_mm1  = (acc == modulus - ONE);
    status.x_zero   = (x == '0);
    status.mul_done = mdone;
    status.div_done = ddone;
  end

  // control flags of the serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      ddone <= 1'b0;
      case (cmd)
        OP_MUL_AB, OP_POW_MUL, OP_POW_SQR, OP_EUC_MUL,
        OP_SQ_D, OP_SQ_DINV, OP_SQ_XC, OP_SQ_CC: begin
          mbusy <= 1'b1;
        end
        OP_EUC_DIV, OP_NR_DIV: begin
          dbusy <= 1'b1;
        end
        default: begin
        end
      endcase
      if (mbusy && mcnt == '0) begin
        mbusy <= 1'b0;
        mdone <= 1'b1;
      end
      if (dbusy && dcnt == '0) begin
        dbusy <= 1'b0;
        ddone <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (load) begin
      op  <= in_op;
      bad <= (in_a >= 32'(modulus)) ||
             ((in_op == OPC_ADD || in_op == OPC_SUB || in_op == OPC_MUL) &&
              (in_b >= 32'(modulus)));
      a   <= in_a[WIDTH-1:0];
      b   <= in_b[WIDTH-1:0];
      e   <= in_b;
    end

    case (cmd)
      OP_ADD: begin res <= add_res; err <= 1'b0; end
      OP_SUB: begin res <= sub_res; err <= 1'b0; end
      OP_NEG: begin res <= neg_res; err <= 1'b0; end
      OP_ERR: begin res <= '0;      err <= 1'b1; end
      OP_POW_AB: begin acc <= ONE; base <= a; end
      OP_POW_SQ3: begin
        acc <= ONE; base <= a; e <= 32'((modulus >> 2) + ONE);
      end
      OP_POW_AT: begin acc <= ONE; base <= a; e <= 32'((t >> 1) + ONE); end
      OP_POW_NT: begin acc <= ONE; base <= r; e <= 32'(t); end
      OP_POW_DS: begin acc <= ONE; base <= d; e <= 32'(s); end
      OP_POW_LEG: begin
        acc <= ONE; base <= a; e <= 32'((modulus - ONE) >> 1);
      end
      OP_POW_SQR: e <= e >> 1;
      OP_EUC_INIT: begin x <= a; y <= modulus; ca <= ONE; cb <= '0; end
      OP_EUC_UPD: begin y <= x; x <= r; cb <= ca; ca <= nc; end
      OP_EUC_FIN: inv <= (y == ONE) ? cb : '0;
      OP_T_INIT: begin t <= modulus - ONE; s <= ONE; end
      OP_T_STEP: begin t <= t >> 1; s <= s << 1; end
      OP_S_INIT: s <= s >> 2;
      OP_S_HALF: s <= s >> 1;
      OP_X_ACC: x <= acc;
      OP_C_ACC: c <= acc;
      OP_RES_ACC: begin res <= acc; err <= 1'b0; end
      OP_RES_X:   begin res <= x;   err <= 1'b0; end
      OP_RES_INV: begin res <= inv; err <= 1'b0; end
      OP_RES_LEG: begin res <= (acc == ONE) ? ONE : '0; err <= 1'b0; end
      default: begin
      end
    endcase

    // multiplier: load operands
    mcnt <= mcnt - CW'(1);
    mr   <= mr_next;
    mwalk <= mwalk << 1;
    case (cmd)
      OP_MUL_AB:  begin mwalk <= a;    madd <= b;    end
      OP_POW_MUL: begin mwalk <= acc;  madd <= base; end
      OP_POW_SQR: begin mwalk <= base; madd <= base; end
      OP_EUC_MUL: begin mwalk <= q;    madd <= ca;   end
      OP_SQ_D:    begin mwalk <= x;    madd <= x;    end
      OP_SQ_DINV: begin mwalk <= d;    madd <= inv;  end
      OP_SQ_XC:   begin mwalk <= x;    madd <= c;    end
      OP_SQ_CC:   begin mwalk <= c;    madd <= c;    end
      default: begin
      end
    endcase
    case (cmd)
      OP_MUL_AB, OP_POW_MUL, OP_POW_SQR, OP_EUC_MUL,
      OP_SQ_D, OP_SQ_DINV, OP_SQ_XC, OP_SQ_CC: begin
        mr   <= '0;
        mcnt <= CNT_LAST;
        mdst <= cmd;
      end
      default: begin
      end
    endcase
    // multiplier: write back on the last step
    if (mbusy && mcnt == '0) begin
      case (mdst)
        OP_MUL_AB:  begin res <= mr_next; err <= 1'b0; end
        OP_POW_MUL: acc  <= mr_next;
        OP_POW_SQR: base <= mr_next;
        OP_EUC_MUL: tmp  <= mr_next;
        OP_SQ_D:    d    <= mr_next;
        OP_SQ_DINV: d    <= mr_next;
        OP_SQ_XC:   x    <= mr_next;
        OP_SQ_CC:   c    <= mr_next;
        default: begin
        end
      endcase
    end

    // divider
    dcnt <= dcnt - CW'(1);
    dq   <= {dq[WIDTH-2:0], qbit};
    drem <= div_try[WIDTH-1:0];
    case (cmd)
      OP_EUC_DIV: begin dq <= y; dden <= x; drem <= '0; dcnt <= CNT_LAST; end
      OP_NR_DIV: begin
        dq <= nonresidue; dden <= modulus; drem <= '0; dcnt <= CNT_LAST;
      end
      default: begin
      end
    endcase
    if (dbusy && dcnt == '0) begin
      q <= {dq[WIDTH-2:0], qbit};
      r <= div_try[WIDTH-1:0];
    end
  end

endmodule

/* rtl/core/pfalu_ctrl.sv */
// ----------------------------------------------------------------------------
// pfalu_ctrl
// Controller: sequences the micro-operations of each opcode, including the
// square-and-multiply loop, extended Euclid and the Tonelli-Shanks loop.
// ----------------------------------------------------------------------------
module pfalu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_free,
  output logic                  out_load,
  input  pfalu_pkg::dp_status_t status,
  output pfalu_pkg::dp_op_t     cmd
);
  import pfalu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH, ST_MUL, ST_MUL_WAIT,
    ST_PW_TEST, ST_PW_MUL, ST_PW_MUL_WAIT, ST_PW_SQR, ST_PW_SQR_WAIT,
    ST_EU_TEST, ST_EU_DIV, ST_EU_DIV_WAIT, ST_EU_UPD,
    ST_SQ_T, ST_SQ_TSTEP, ST_SQ_PX, ST_SQ_XA, ST_SQ_NR, ST_SQ_NR_WAIT,
    ST_SQ_PC, ST_SQ_CA, ST_SQ_LOOP, ST_SQ_DI, ST_SQ_D1, ST_SQ_CHK,
    ST_SQ_CC, ST_SQ_SH,
    ST_RES_X, ST_RES_ACC, ST_RES_LEG, ST_RES_INV, ST_OUT
  } state_t;

  state_t state, state_next;
  state_t mret, mret_next;   // return after a generic multiply
  state_t pret, pret_next;   // return after a power loop
  state_t eret, eret_next;   // return after extended Euclid
  dp_op_t mop, mop_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    mret_next  = mret;
    pret_next  = pret;
    eret_next  = eret;
    mop_next   = mop;
    cmd        = OP_NOP;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.m_small || status.bad) begin
          cmd = OP_ERR; state_next = ST_OUT;
        end else begin
          case (status.op)
            OPC_ADD: begin cmd = OP_ADD; state_next = ST_OUT; end
            OPC_SUB: begin cmd = OP_SUB; state_next = ST_OUT; end
            OPC_NEG: begin cmd = OP_NEG; state_next = ST_OUT; end
            OPC_MUL: begin
              mop_next = OP_MUL_AB; mret_next = ST_OUT; state_next = ST_MUL;
            end
            OPC_INV: begin
              cmd = OP_EUC_INIT; eret_next = ST_RES_INV; state_next = ST_EU_TEST;
            end
            OPC_POW: begin
              cmd = OP_POW_AB; pret_next = ST_RES_ACC; state_next = ST_PW_TEST;
            end
            OPC_SQRT: begin
              if (status.m_mod3) begin
                cmd = OP_POW_SQ3; pret_next = ST_RES_ACC; state_next = ST_PW_TEST;
              end else begin
                cmd = OP_EUC_INIT; eret_next = ST_SQ_T; state_next = ST_EU_TEST;
              end
            end
            default: begin
              cmd = OP_POW_LEG; pret_next = ST_RES_LEG; state_next = ST_PW_TEST;
            end
          endcase
        end
      end
      // generic multiply
      ST_MUL: begin cmd = mop; state_next = ST_MUL_WAIT; end
      ST_MUL_WAIT: if (status.mul_done) state_next = mret;
      // square and multiply
      ST_PW_TEST: begin
        if (status.e_zero) state_next = pret;
        else if (status.e_lsb) state_next = ST_PW_MUL;
        else state_next = ST_PW_SQR;
      end
      ST_PW_MUL: begin cmd = OP_POW_MUL; state_next = ST_PW_MUL_WAIT; end
      ST_PW_MUL_WAIT: if (status.mul_done) state_next = ST_PW_SQR;
      ST_PW_SQR: begin cmd = OP_POW_SQR; state_next = ST_PW_SQR_WAIT; end
      ST_PW_SQR_WAIT: if (status.mul_done) state_next = ST_PW_TEST;
      // extended Euclid
      ST_EU_TEST: begin
        if (status.x_zero) begin
          cmd = OP_EUC_FIN; state_next = eret;
        end else begin
          state_next = ST_EU_DIV;
        end
      end
      ST_EU_DIV: begin cmd = OP_EUC_DIV; state_next = ST_EU_DIV_WAIT; end
      ST_EU_DIV_WAIT: begin
        if (status.div_done) begin
          mop_next = OP_EUC_MUL; mret_next = ST_EU_UPD; state_next = ST_MUL;
        end
      end
      ST_EU_UPD: begin cmd = OP_EUC_UPD; state_next = ST_EU_TEST; end
      // Tonelli-Shanks setup
      ST_SQ_T: begin cmd = OP_T_INIT; state_next = ST_SQ_TSTEP; end
      ST_SQ_TSTEP: begin
        if (status.t_lsb) begin
          cmd = OP_S_INIT; state_next = ST_SQ_PX;
        end else begin
          cmd = OP_T_STEP;
        end
      end
      ST_SQ_PX: begin
        cmd = OP_POW_AT; pret_next = ST_SQ_XA; state_next = ST_PW_TEST;
      end
      ST_SQ_XA: begin cmd = OP_X_ACC; state_next = ST_SQ_NR; end
      ST_SQ_NR: begin cmd = OP_NR_DIV; state_next = ST_SQ_NR_WAIT; end
      ST_SQ_NR_WAIT: if (status.div_done) state_next = ST_SQ_PC;
      ST_SQ_PC: begin
        cmd = OP_POW_NT; pret_next = ST_SQ_CA; state_next = ST_PW_TEST;
      end
      ST_SQ_CA: begin cmd = OP_C_ACC; state_next = ST_SQ_LOOP; end
      // Tonelli-Shanks loop
      ST_SQ_LOOP: begin
        if (status.s_zero) begin
          state_next = ST_RES_X;
        end else begin
          mop_next = OP_SQ_D; mret_next = ST_SQ_DI; state_next = ST_MUL;
        end
      end
      ST_SQ_DI: begin
        mop_next = OP_SQ_DINV; mret_next = ST_SQ_D1; state_next = ST_MUL;
      end
      ST_SQ_D1: begin
        if (status.d_one) begin
          state_next = ST_RES_X;
        end else begin
          cmd = OP_POW_DS; pret_next = ST_SQ_CHK; state_next = ST_PW_TEST;
        end
      end
      ST_SQ_CHK: begin
        if (status.acc_mm1) begin
          mop_next = OP_SQ_XC; mret_next = ST_SQ_CC; state_next = ST_MUL;
        end else begin
          state_next = ST_SQ_CC;
        end
      end
      ST_SQ_CC: begin
        mop_next = OP_SQ_CC; mret_next = ST_SQ_SH; state_next = ST_MUL;
      end
      ST_SQ_SH: begin cmd = OP_S_HALF; state_next = ST_SQ_LOOP; end
      // result selection
      ST_RES_X:   begin cmd = OP_RES_X;   state_next = ST_OUT; end
      ST_RES_ACC: begin cmd = OP_RES_ACC; state_next = ST_OUT; end
      ST_RES_LEG: begin cmd = OP_RES_LEG; state_next = ST_OUT; end
      ST_RES_INV: begin cmd = OP_RES_INV; state_next = ST_OUT; end
      ST_OUT: begin
        out_load = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mret  <= ST_IDLE;
      pret  <= ST_IDLE;
      eret  <= ST_IDLE;
      mop   <= OP_NOP;
    end else begin
      state <= state_next;
      mret  <= mret_next;
      pret  <= pret_next;
      eret  <= eret_next;
      mop   <= mop_next;
    end
  end

endmodule

/* rtl/core/prime_field_alu_unit.sv */
// ----------------------------------------------------------------------------
// prime_field_alu_unit
// Arithmetic modulo a configured prime: add, sub, mul, neg, inverse, power,
// square root and Legendre test, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, results leave on
//   m_tvalid/m_tready/m_tdata. Modulus and non-residue are written through
//   cfg_we/cfg_index/cfg_data while the unit is idle.
//   One beat is worked at a time; s_tready is high while no beat is in work.
//   Add/sub/neg finish without a serial unit, mul is one multiply, power
//   is a square-and-multiply loop over the exponent, inverse is one division
//   and one multiply per Euclid step; square root is one power loop when
//   p = 3 mod 4, else its Euclid pass, two power loops and its inner loop.
//   Every modular multiply is one bit-serial pass through a single shared
//   multiplier; divisions use a bit-serial restoring divider.
//   The next beat is taken in the cycle after its result is loaded.
//   The result sits in an output register, so a new beat is taken while
//   an earlier result still waits; a finished result holds the unit until
//   that register is free.
//   Reset clears control state, sets modulus to 11 and non-residue to 2.
// ----------------------------------------------------------------------------
module prime_field_alu_unit #(
  parameter int WIDTH = pfalu_pkg::PFA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pfalu_pkg::IN_TDATA_W-1:0]   s_tdata,   // op, operand_a, operand_b
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pfalu_pkg::OUT_TDATA_W-1:0]  m_tdata,   // value, operand_error
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [WIDTH-1:0]                   cfg_data
);
  import pfalu_pkg::*;

  logic [WIDTH-1:0] modulus, nonresidue;
  logic             in_accept, out_free, out_load;
  dp_status_t       status;
  dp_op_t           cmd;
  logic [WIDTH-1:0] res;
  logic             err;
  logic [31:0]      out_value;
  logic             out_err;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= WIDTH'(MOD_RESET);
      nonresidue <= WIDTH'(NR_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:    modulus    <= cfg_data;
        REG_NONRESIDUE: nonresidue <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pfalu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  pfalu_dp #(.WIDTH(WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .modulus    (modulus),
    .nonresidue (nonresidue),
    .load       (in_accept),
    .in_op      (alu_op_t'(s_tdata[2:0])),
    .in_a       (s_tdata[34:3]),
    .in_b       (s_tdata[66:35]),
    .cmd        (cmd),
    .status     (status),
    .res        (res),
    .err        (err)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= 32'(res);
      out_err   <= err;
    end
  end

  assign m_tdata = {7'd0, out_err, out_value};

endmodule
